// ===== sv/teu_pkg.sv =====
// shared types, constants and the hardware trap-type table for the trap entry unit
`default_nettype none

package teu_pkg;

   localparam int unsigned TRAP_BASE_W  = 20;
   localparam int unsigned TRAP_TYPE_W  = 8;
   localparam int unsigned WINDOW_W     = 5;
   localparam int unsigned ADDR_W       = 32;
   localparam int unsigned HW_TABLE_SIZE = 22;
   localparam int unsigned HW_INDEX_W   = 5;
   localparam int unsigned REQ_DATA_W   = 80;
   localparam int unsigned RSP_DATA_W   = 152;

   localparam logic [ADDR_W-1:0] JUMP_STEP = 32'd4;

   // fixed hardware trap types, indexed by trap code
   localparam logic [TRAP_TYPE_W-1:0] HW_TYPES [HW_TABLE_SIZE] = '{
      8'h00, 8'h2B, 8'h3C, 8'h21, 8'h20, 8'h01, 8'h03, 8'h02, 8'h04, 8'h24, 8'h25,
      8'h0B, 8'h05, 8'h06, 8'h07, 8'h08, 8'h28, 8'h29, 8'h2C, 8'h09, 8'h0A, 8'h2A
   };

   typedef enum logic {
      CMD_SIGNAL  = 1'b0,
      CMD_TRIGGER = 1'b1
   } command_type;

   // request fields, last field in the lowest bits
   typedef struct packed {
      logic [ADDR_W-1:0]      next_counter;
      logic [ADDR_W-1:0]      program_counter;
      logic [WINDOW_W-1:0]    window_pointer;
      logic                   supervisor;
      logic                   enable_traps;
      logic [TRAP_TYPE_W-1:0] trap_code;
   } req_item_type;

   // result fields, last field in the lowest bits
   typedef struct packed {
      logic [ADDR_W-1:0]      jump_npc;
      logic [ADDR_W-1:0]      jump_pc;
      logic [ADDR_W-1:0]      saved_npc;
      logic [ADDR_W-1:0]      saved_pc;
      logic                   taken;
      logic [WINDOW_W-1:0]    new_window;
      logic                   previous_supervisor;
      logic                   new_supervisor;
      logic                   new_enable;
      logic [TRAP_TYPE_W-1:0] trap_type;
      logic                   pending;
      logic                   status;
   } rsp_item_type;

   // architectural trap state carried between beats
   typedef struct packed {
      logic                   halted;
      logic                   pending;
      logic [TRAP_TYPE_W-1:0] held_type;
   } trap_state_type;

endpackage

`default_nettype wire

// ===== sv/teu_step.sv =====
// one-pass trap signal / trap entry logic: result and next trap state from one beat
`default_nettype none

module teu_step
   import teu_pkg::*;
#(
   parameter int unsigned WINDOW_COUNT = 8
) (
   input  command_type             command,
   input  req_item_type            item,
   input  trap_state_type          state,
   input  logic [TRAP_BASE_W-1:0]  trap_base,
   output trap_state_type          state_next,
   output rsp_item_type            result
);

   localparam int unsigned WIN_VALUES = 1 << WINDOW_W;
   localparam logic [WINDOW_W-1:0] LAST_WINDOW = WINDOW_W'(WINDOW_COUNT - 1);

   logic [WINDOW_W-1:0]    win_mod [WIN_VALUES];
   logic [WINDOW_W-1:0]    win_reduced;
   logic [WINDOW_W-1:0]    win_dec;
   logic [TRAP_TYPE_W-1:0] signal_type;
   logic [ADDR_W-1:0]      tbr;

   // window pointer reduced modulo the window count, built at elaboration
   for (genvar i = 0; i < WIN_VALUES; i++) begin : g_win_mod
      assign win_mod[i] = WINDOW_W'(i % WINDOW_COUNT);
   end

   assign win_reduced = win_mod[item.window_pointer];
   assign win_dec     = (win_reduced == '0) ? LAST_WINDOW : win_reduced - 1'b1;

   assign signal_type = (item.trap_code < TRAP_TYPE_W'(HW_TABLE_SIZE))
                        ? HW_TYPES[item.trap_code[HW_INDEX_W-1:0]]
                        : item.trap_code;

   assign tbr = {trap_base, state.held_type, 4'b0000};

   always_comb begin
      state_next                 = state;
      result                     = '0;
      result.new_enable          = item.enable_traps;
      result.new_supervisor      = item.supervisor;
      result.new_window          = item.window_pointer;

      if (state.halted) begin
         result.status = 1'b1;
      end else begin
         case (command)
            CMD_SIGNAL: begin
               state_next.held_type = signal_type;
               state_next.pending   = 1'b1;
            end
            CMD_TRIGGER: begin
               if (item.enable_traps) begin
                  result.new_enable          = 1'b0;
                  result.previous_supervisor = item.supervisor;
                  result.new_supervisor      = 1'b1;
                  result.new_window          = win_dec;
                  result.taken               = 1'b1;
                  result.saved_pc            = item.program_counter;
                  result.saved_npc           = item.next_counter;
                  result.jump_pc             = tbr;
                  result.jump_npc            = tbr + JUMP_STEP;
               end else begin
                  // entry with traps disabled: error mode
                  state_next.halted = 1'b1;
                  result.status     = 1'b1;
                  result.new_enable = 1'b0;
               end
            end
            default: begin
               state_next = state;
            end
         endcase
      end

      result.pending   = state_next.pending;
      result.trap_type = state_next.held_type;
   end

endmodule

`default_nettype wire

// ===== sv/trap_entry_unit.sv =====
// top level of the trap entry unit: beat registers, trap state and result register
`default_nettype none

// trap entry unit: a signal beat (tuser 0) loads the trap type into the TT
// field and raises pending; a trigger beat (tuser 1) performs trap entry when
// ET is set and jumps to TBR and TBR+4, or halts in error mode when ET is
// clear, after which every beat returns status 1 until reset. every request
// beat gives exactly one response beat. a beat is captured in the request
// register, passes the combinational trap logic and lands in the response
// register, or waits in the request register while that one is full. the
// single pass through the trap logic sets the rate at one beat per cycle
// while responses are drained. while a response waits the request register
// still takes one beat, then the request side stalls until the response is
// taken. csr writes load the TBA field; the user must make them only while no
// beat is in flight, since the block itself does not enforce this.

module trap_entry_unit
   import teu_pkg::*;
#(
   parameter int unsigned WINDOW_COUNT = 8
) (
   input  logic                    clock,
   input  logic                    reset,
   // request channel
   input  logic                    req_tvalid,
   output logic                    req_tready,
   // trap_code[7:0], enable_traps[8], supervisor[9], window_pointer[14:10],
   // program_counter[46:15], next_counter[78:47], zero[79]
   input  logic [REQ_DATA_W-1:0]   req_tdata,
   // command[0]: 0 signal a trap, 1 trigger trap entry
   input  logic [0:0]              req_tuser,
   // response channel
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   // status[0], pending[1], trap_type[9:2], new_enable[10], new_supervisor[11],
   // previous_supervisor[12], new_window[17:13], taken[18], saved_pc[50:19],
   // saved_npc[82:51], jump_pc[114:83], jump_npc[146:115], zero[151:147]
   output logic [RSP_DATA_W-1:0]   rsp_tdata,
   // trap base address write
   input  logic                    csr_write_en,
   input  logic [TRAP_BASE_W-1:0]  csr_write_data
);

   localparam int unsigned REQ_ITEM_W = $bits(req_item_type);
   localparam int unsigned RSP_ITEM_W = $bits(rsp_item_type);

   // request register
   logic            req_valid_ff;
   logic            req_valid_in;
   req_item_type    req_item_ff;
   command_type     req_cmd_ff;

   // response register
   logic            rsp_valid_ff;
   logic            rsp_valid_in;
   rsp_item_type    rsp_item_ff;

   // trap state and tba
   trap_state_type          state_ff;
   trap_state_type          state_in;
   logic [TRAP_BASE_W-1:0]  trap_base_ff;

   trap_state_type  step_state;
   rsp_item_type    step_result;

   logic            req_fire;
   logic            advance;

   // the request register moves on when the response register is free or drains
   assign advance    = req_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !req_valid_ff || advance;
   assign req_fire   = req_tvalid && req_tready;

   assign req_valid_in = req_fire || (req_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp_tready);
   assign state_in     = advance ? step_state : state_ff;

   teu_step #(
      .WINDOW_COUNT (WINDOW_COUNT)
   ) u_step (
      .command    (req_cmd_ff),
      .item       (req_item_ff),
      .state      (state_ff),
      .trap_base  (trap_base_ff),
      .state_next (step_state),
      .result     (step_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= '0;
         trap_base_ff <= '0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         state_ff     <= state_in;
         if (csr_write_en) begin
            trap_base_ff <= csr_write_data;
         end
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (req_fire) begin
         req_item_ff <= req_item_type'(req_tdata[REQ_ITEM_W-1:0]);
         req_cmd_ff  <= command_type'(req_tuser[0]);
      end
      if (advance) begin
         rsp_item_ff <= step_result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - RSP_ITEM_W){1'b0}}, rsp_item_ff};

   // error mode is left only through reset
   a_halt_sticky : assert property (@(posedge clock) disable iff (reset)
      state_ff.halted |=> state_ff.halted)
      else $error("halted flag cleared without reset");

   // every beat processed in error mode reports status 1
   a_halt_status : assert property (@(posedge clock) disable iff (reset)
      advance && state_ff.halted |=> rsp_item_ff.status)
      else $error("beat processed while halted without halted status");

   // trap state only moves when a beat passes through the trap logic
   a_state_hold : assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(state_ff))
      else $error("trap state changed without a beat");

   // trap entry and error mode never come together
   a_taken_ok : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_item_ff.taken |-> !rsp_item_ff.status)
      else $error("taken trap reported with halted status");

   // an empty response register never holds back the request side
   a_ready_free : assert property (@(posedge clock) disable iff (reset)
      !rsp_valid_ff |-> req_tready)
      else $error("request stalled with empty response register");

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// self-checking testbench for the trap entry unit: directed and random beats against a predictor
`default_nettype none

module tb;
   import teu_pkg::*;

   localparam int unsigned WINDOWS        = 8;
   localparam int unsigned TYPE_ROM_SIZE  = 22;
   localparam int unsigned FIELD_COUNT    = 12;
   localparam int unsigned RANDOM_PHASES  = 5;
   localparam int unsigned PHASE_BEATS    = 220;
   localparam int unsigned HALTED_BEATS   = 30;
   localparam int unsigned LONG_HOLD      = 150;
   localparam int unsigned TIMEOUT_CYCLES = 300000;

   // what the stimulus queue can ask of the driver
   typedef enum logic [1:0] {
      OP_BEAT  = 2'd0,
      OP_DRAIN = 2'd1,
      OP_CSR   = 2'd2
   } op_kind_type;

   typedef struct packed {
      op_kind_type             kind;
      command_type             cmd;
      req_item_type            body;
      logic [TRAP_BASE_W-1:0]  base;
   } stim_op_type;

   // hardware trap types by trap code
   localparam logic [7:0] TYPE_ROM [TYPE_ROM_SIZE] = '{
      8'h00, 8'h2B, 8'h3C, 8'h21, 8'h20, 8'h01, 8'h03, 8'h02, 8'h04, 8'h24, 8'h25,
      8'h0B, 8'h05, 8'h06, 8'h07, 8'h08, 8'h28, 8'h29, 8'h2C, 8'h09, 8'h0A, 8'h2A
   };

   string field_names [FIELD_COUNT] = '{
      "status", "pending", "trap_type", "new_enable", "new_supervisor",
      "previous_supervisor", "new_window", "taken", "saved_pc", "saved_npc",
      "jump_pc", "jump_npc"
   };

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_DATA_W-1:0]  req_tdata = '0;
   logic [0:0]             req_tuser = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic                   csr_write_en = 1'b0;
   logic [TRAP_BASE_W-1:0] csr_write_data = '0;

   trap_entry_unit #(.WINDOW_COUNT(WINDOWS)) dut (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data)
   );

   always #6 clock = ~clock;

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
   end

   // ---------------------------------------------------------------------
   // stimulus: ops queue filled at time zero, consumed by the driver
   // ---------------------------------------------------------------------
   stim_op_type stim_ops [$];

   task automatic add_beat(input command_type cmd, input logic [7:0] code, input logic et,
                           input logic s, input logic [4:0] cwp, input logic [31:0] pc,
                           input logic [31:0] npc);
      stim_op_type op;
      op = '0;
      op.kind = OP_BEAT;
      op.cmd = cmd;
      op.body.trap_code = code;
      op.body.enable_traps = et;
      op.body.supervisor = s;
      op.body.window_pointer = cwp;
      op.body.program_counter = pc;
      op.body.next_counter = npc;
      stim_ops.push_back(op);
   endtask

   // sender waits until every response is back
   task automatic add_drain();
      stim_op_type op;
      op = '0;
      op.kind = OP_DRAIN;
      stim_ops.push_back(op);
   endtask

   // tba write, only with nothing in flight
   task automatic add_base(input logic [TRAP_BASE_W-1:0] value);
      stim_op_type op;
      add_drain();
      op = '0;
      op.kind = OP_CSR;
      op.base = value;
      stim_ops.push_back(op);
   endtask

   // pc/npc values with the extremes showing up often
   function automatic logic [31:0] wide_value();
      case ($urandom_range(0, 7))
         0: return 32'h0000_0000;
         1: return 32'hFFFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   // allow_halt: triggers may carry et 0, which halts the block for good
   task automatic add_random_beat(input bit allow_halt);
      command_type cmd;
      logic [7:0]  code;
      logic        et;
      cmd = $urandom_range(0, 1) ? CMD_TRIGGER : CMD_SIGNAL;
      // half the codes are drawn from the hardware table range
      code = $urandom_range(0, 1) ? 8'($urandom_range(0, TYPE_ROM_SIZE - 1))
                                  : 8'($urandom_range(0, 255));
      et = 1'($urandom_range(0, 1));
      if (cmd == CMD_TRIGGER && !allow_halt)
         et = 1'b1;
      add_beat(cmd, code, et, 1'($urandom_range(0, 1)), 5'($urandom_range(0, 31)),
               wide_value(), wide_value());
   endtask

   initial begin
      logic [TRAP_BASE_W-1:0] phase_base [RANDOM_PHASES];
      phase_base = '{20'h00000, 20'hFFFFF, 20'($urandom), 20'h80001, 20'h7FFFE};

      // directed: table ends, software types, window wrap and out-of-range windows
      add_base(20'hFFFFF);
      add_beat(CMD_SIGNAL,  8'd0,   1'b0, 1'b0, 5'd0,  32'h0, 32'h0);
      add_beat(CMD_SIGNAL,  8'd1,   1'b1, 1'b1, 5'd31, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      add_beat(CMD_SIGNAL,  8'd21,  1'b0, 1'b1, 5'd3,  32'h0, 32'h0);
      add_beat(CMD_SIGNAL,  8'd22,  1'b1, 1'b0, 5'd4,  32'h0, 32'h0);
      add_beat(CMD_SIGNAL,  8'd255, 1'b0, 1'b0, 5'd5,  32'h0, 32'h0);
      add_beat(CMD_TRIGGER, 8'd0,   1'b1, 1'b0, 5'd0,  32'h0, 32'hFFFF_FFFF);
      add_beat(CMD_TRIGGER, 8'd255, 1'b1, 1'b1, 5'd31, 32'hFFFF_FFFF, 32'h0);
      add_beat(CMD_TRIGGER, 8'd0,   1'b1, 1'b0, 5'd8,  32'h1234_5678, 32'h1234_567C);
      add_beat(CMD_TRIGGER, 8'd0,   1'b1, 1'b1, 5'd7,  32'hA5A5_A5A5, 32'h5A5A_5A5A);
      add_beat(CMD_SIGNAL,  8'd128, 1'b1, 1'b1, 5'd16, 32'h0, 32'h0);
      add_beat(CMD_TRIGGER, 8'd0,   1'b1, 1'b0, 5'd1,  32'h8000_0000, 32'h8000_0004);
      add_beat(CMD_SIGNAL,  8'd10,  1'b0, 1'b1, 5'd9,  32'h0, 32'h0);
      add_base(20'h00000);
      add_beat(CMD_TRIGGER, 8'd0,   1'b1, 1'b1, 5'd24, 32'h0000_0004, 32'h0000_0008);
      add_beat(CMD_SIGNAL,  8'd7,   1'b0, 1'b0, 5'd2,  32'h0, 32'h0);
      add_beat(CMD_TRIGGER, 8'd0,   1'b1, 1'b0, 5'd15, 32'hFFFF_FFFC, 32'h0000_0000);

      // random phases, each under its own tba, with the odd full drain inside
      foreach (phase_base[p]) begin
         add_base(phase_base[p]);
         for (int n = 0; n < PHASE_BEATS; n++) begin
            add_random_beat(1'b0);
            if ($urandom_range(0, 49) == 0)
               add_drain();
         end
      end

      // halt: trigger with et clear, after that every beat reports status 1
      add_base(20'($urandom));
      add_beat(CMD_SIGNAL,  8'd3, 1'b1, 1'b0, 5'd6, 32'h0, 32'h0);
      add_beat(CMD_TRIGGER, 8'd0, 1'b0, 1'b1, 5'd6, 32'hDEAD_0000, 32'hDEAD_0004);
      for (int n = 0; n < HALTED_BEATS; n++)
         add_random_beat(1'b1);
   end

   // ---------------------------------------------------------------------
   // driver: offers one op at a time, random gap after each beat
   // ---------------------------------------------------------------------
   int unsigned send_gap;
   int unsigned beats_sent;
   int unsigned in_flight;      // responses owed, as of the previous edge
   logic        drv_valid;
   logic        drv_write;

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid     <= 1'b0;
         req_tdata      <= '0;
         req_tuser      <= '0;
         csr_write_en   <= 1'b0;
         csr_write_data <= '0;
         send_gap = 0;
         beats_sent = 0;
      end else begin
         // a beat not yet taken stays on the bus unchanged
         drv_valid = req_tvalid && !req_tready;
         drv_write = 1'b0;
         if (!drv_valid) begin
            if (send_gap > 0) begin
               send_gap = send_gap - 1;
            end else if (stim_ops.size() != 0) begin
               case (stim_ops[0].kind)
                  OP_BEAT: begin
                     req_tdata <= {1'b0, stim_ops[0].body};
                     req_tuser <= stim_ops[0].cmd;
                     drv_valid = 1'b1;
                     beats_sent = beats_sent + 1;
                     // stretches with no gaps at all
                     send_gap = (beats_sent % 128 < 32) ? 0 : $urandom_range(0, 9);
                     void'(stim_ops.pop_front());
                  end
                  OP_DRAIN: begin
                     if (!req_tvalid && in_flight == 0)
                        void'(stim_ops.pop_front());
                  end
                  default: begin
                     csr_write_data <= stim_ops[0].base;
                     drv_write = 1'b1;
                     void'(stim_ops.pop_front());
                  end
               endcase
            end
         end
         req_tvalid   <= drv_valid;
         csr_write_en <= drv_write;
      end
   end

   // ---------------------------------------------------------------------
   // receiver: random stall per response, two long hold-offs
   // ---------------------------------------------------------------------
   int unsigned rsp_stall;
   int unsigned rsp_taken;

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_stall = 0;
         rsp_taken = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            rsp_taken = rsp_taken + 1;
            // long hold-off lets the request side back up against a full block
            if (rsp_taken == 300 || rsp_taken == 800)
               rsp_stall = LONG_HOLD;
            else if (rsp_taken % 100 < 25)
               rsp_stall = 0;
            else
               rsp_stall = $urandom_range(0, 9);
         end else if (rsp_stall > 0) begin
            rsp_stall = rsp_stall - 1;
         end
         rsp_tready <= (rsp_stall == 0);
      end
   end

   // ---------------------------------------------------------------------
   // predictor: trap state mirrored from the observed bus
   // ---------------------------------------------------------------------
   logic [TRAP_BASE_W-1:0] mirror_base;
   logic [7:0]             mirror_type;
   logic                   mirror_pending;
   logic                   mirror_halted;
   rsp_item_type           due_results [$];
   int unsigned            mismatches = 0;

   function automatic rsp_item_type trap_outcome(input command_type cmd,
                                                 input req_item_type rq);
      int unsigned  w;
      logic [31:0]  tbr;
      rsp_item_type r;
      r = '0;
      // no entry: psr fields echo the request
      r.new_enable = rq.enable_traps;
      r.new_supervisor = rq.supervisor;
      r.new_window = rq.window_pointer;
      if (mirror_halted) begin
         r.status = 1'b1;
      end else if (cmd == CMD_SIGNAL) begin
         mirror_type = (rq.trap_code < TYPE_ROM_SIZE) ? TYPE_ROM[rq.trap_code[4:0]]
                                                      : rq.trap_code;
         mirror_pending = 1'b1;
      end else if (rq.enable_traps) begin
         // out-of-range windows fold first, then step down with wrap
         w = rq.window_pointer % WINDOWS;
         r.new_enable = 1'b0;
         r.previous_supervisor = rq.supervisor;
         r.new_supervisor = 1'b1;
         r.new_window = 5'((w == 0) ? WINDOWS - 1 : w - 1);
         r.taken = 1'b1;
         r.saved_pc = rq.program_counter;
         r.saved_npc = rq.next_counter;
         tbr = {mirror_base, mirror_type, 4'h0};
         r.jump_pc = tbr;
         r.jump_npc = tbr + 32'd4;
      end else begin
         // entry with traps disabled: error mode until reset
         mirror_halted = 1'b1;
         r.status = 1'b1;
         r.new_enable = 1'b0;
      end
      r.pending = mirror_pending;
      r.trap_type = mirror_type;
      return r;
   endfunction

   function automatic logic [FIELD_COUNT-1:0][31:0] result_fields(input rsp_item_type r);
      return {r.jump_npc, r.jump_pc, r.saved_npc, r.saved_pc, 32'(r.taken),
              32'(r.new_window), 32'(r.previous_supervisor), 32'(r.new_supervisor),
              32'(r.new_enable), 32'(r.trap_type), 32'(r.pending), 32'(r.status)};
   endfunction

   // ---------------------------------------------------------------------
   // monitor: tracks csr writes and request beats, checks response beats
   // ---------------------------------------------------------------------
   logic [FIELD_COUNT-1:0][31:0] want_fields;
   logic [FIELD_COUNT-1:0][31:0] got_fields;

   always @(posedge clock) begin
      if (reset) begin
         mirror_base = '0;
         mirror_type = '0;
         mirror_pending = 1'b0;
         mirror_halted = 1'b0;
         due_results.delete();
         in_flight <= 0;
      end else begin
         if (csr_write_en)
            mirror_base = csr_write_data;
         if (req_tvalid && req_tready)
            due_results.push_back(trap_outcome(command_type'(req_tuser[0]),
                                               req_item_type'(req_tdata[78:0])));
         if (rsp_tvalid && rsp_tready) begin
            if (due_results.size() == 0) begin
               mismatches = mismatches + 1;
               if (mismatches <= 10)
                  $display("response beat with nothing due: %h", rsp_tdata);
            end else begin
               want_fields = result_fields(due_results.pop_front());
               got_fields = result_fields(rsp_item_type'(rsp_tdata[146:0]));
               for (int i = 0; i < FIELD_COUNT; i++) begin
                  if (want_fields[i] !== got_fields[i]) begin
                     mismatches = mismatches + 1;
                     if (mismatches <= 10)
                        $display("mismatch %s: expected %h, got %h",
                                 field_names[i], want_fields[i], got_fields[i]);
                  end
               end
            end
         end
         in_flight <= due_results.size();
      end
   end

   // ---------------------------------------------------------------------
   // end of run: all ops issued, nothing owed, then a short tail
   // ---------------------------------------------------------------------
   initial begin
      @(negedge clock);
      while (reset || stim_ops.size() != 0 || req_tvalid || in_flight != 0)
         @(negedge clock);
      repeat (8) @(negedge clock);
      if (mismatches == 0 && due_results.size() == 0)
         $display("tb: clean");
      else
         $display("tb: errors");
      $finish;
   end

   initial begin
      #(TIMEOUT_CYCLES * 12);
      $display("tb: errors");
      $finish;
   end

endmodule

`default_nettype wire

// ===== trap_entry_unit.f =====
sv/teu_pkg.sv
sv/teu_step.sv
sv/trap_entry_unit.sv
tb/tb.sv
